[hdl/spo_pkg.sv]
// ----------------------------------------------------------------------------
// spo_pkg
// shared widths, constants and pipeline side-band types for the sphere pair
// overlap block
// ----------------------------------------------------------------------------
`default_nettype none

package spo_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned CRD_W         = 32;
  localparam int unsigned RAD_W         = 31;
  localparam int unsigned VOL_W         = 63;

  localparam int unsigned SQRT_STEPS = 35;
  localparam int unsigned DIV_STEPS  = 63;
  localparam int unsigned DIVR_W     = 36;

  // pi in q32, and four times it for the full sphere
  localparam logic [33:0] PI_Q32  = 34'd13493037705;
  localparam logic [35:0] PI4_Q32 = 36'd53972150820;

  localparam logic [VOL_W-1:0] VOL_MAX = '1;

  typedef struct packed {
    logic [31:0]      s;
    logic [61:0]      t2;
    logic [RAD_W-1:0] rs;
    logic             touching;
    logic             contained;
  } sq_side_t;

  typedef struct packed {
    logic                    touching;
    logic                    contained;
    logic signed [CRD_W-1:0] pen;
    logic                    sat;
    logic [DIVR_W-1:0]       e;
    logic [DIV_STEPS-1:0]    nlow;
  } dv_side_t;

endpackage

`default_nettype wire

[hdl/spo_in_if.sv]
// ----------------------------------------------------------------------------
// spo_in_if
// input channel: one sphere pair per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface spo_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [spo_pkg::CRD_W-1:0] center0_x;
  logic signed [spo_pkg::CRD_W-1:0] center0_y;
  logic signed [spo_pkg::CRD_W-1:0] center0_z;
  logic signed [spo_pkg::CRD_W-1:0] center1_x;
  logic signed [spo_pkg::CRD_W-1:0] center1_y;
  logic signed [spo_pkg::CRD_W-1:0] center1_z;
  logic [spo_pkg::RAD_W-1:0]        radius0;
  logic [spo_pkg::RAD_W-1:0]        radius1;

  modport source (
    output valid, center0_x, center0_y, center0_z,
    output center1_x, center1_y, center1_z, radius0, radius1,
    input  ready
  );
  modport sink (
    input  valid, center0_x, center0_y, center0_z,
    input  center1_x, center1_y, center1_z, radius0, radius1,
    output ready
  );
endinterface

`default_nettype wire

[hdl/spo_out_if.sv]
// ----------------------------------------------------------------------------
// spo_out_if
// result channel: contact flags, depth and overlap volume per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface spo_out_if;
  logic                             valid;
  logic                             ready;
  logic                             touching;
  logic                             contained;
  logic signed [spo_pkg::CRD_W-1:0] penetration_depth;
  logic [spo_pkg::VOL_W-1:0]        overlap_volume;

  modport source (
    output valid, touching, contained, penetration_depth, overlap_volume,
    input  ready
  );
  modport sink (
    input  valid, touching, contained, penetration_depth, overlap_volume,
    output ready
  );
endinterface

`default_nettype wire

[hdl/sphere_pair_overlap.sv]
// throughput: one beat per cycle; the pipeline stalls as a whole only while a
// result sits in the output register and is not taken
// the depth is set by the 35-step square root and the 63-step quotient chain
// reset: synchronous active low, clears the valid bits and the output valid register
// ----------------------------------------------------------------------------
// sphere_pair_overlap
// contact test, penetration depth and lens overlap volume of two spheres,
// fully pipelined with a digit-per-stage square root and divider
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_pair_overlap #(
  parameter int unsigned FRAC_BITS = spo_pkg::FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spo_in_if.sink     in_ch,
  spo_out_if.source  out_ch
);

  localparam int unsigned SQN   = spo_pkg::SQRT_STEPS;
  localparam int unsigned DVN   = spo_pkg::DIV_STEPS;
  localparam int unsigned EW    = spo_pkg::DIVR_W;
  localparam int unsigned SHIFT = 2 * FRAC_BITS + 32;
  localparam int unsigned MW    = 133;
  localparam int unsigned XW    = 171;
  localparam int unsigned NW    = XW - SHIFT;
  localparam int unsigned HW    = NW - DVN;
  localparam int unsigned CMPW  = (HW > EW) ? HW : EW;
  localparam int unsigned ST_A  = 3 + SQN;
  localparam int unsigned NST   = ST_A + 8 + DVN;

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] df;
    logic [32:0] ng;
    df = {a[31], a} - {b[31], b};
    ng = -df;
    return df[32] ? ng[31:0] : df[31:0];
  endfunction

  logic en;
  logic in_fire;
  logic [NST-1:0] vld_r;
  logic out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && en;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NST-2:0], in_fire};
      out_valid_r <= vld_r[NST-1];
    end
  end

  // stage 1: coordinate differences, radius ordering
  logic [31:0] s1_dx_r, s1_dy_r, s1_dz_r, s1_s_r;
  logic [30:0] s1_t_r, s1_rs_r;
  logic [30:0] rs_nxt, rl_nxt;

  always_comb begin
    if (in_ch.radius0 < in_ch.radius1) begin
      rs_nxt = in_ch.radius0;
      rl_nxt = in_ch.radius1;
    end else begin
      rs_nxt = in_ch.radius1;
      rl_nxt = in_ch.radius0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r <= abs_diff(in_ch.center0_x, in_ch.center1_x);
      s1_dy_r <= abs_diff(in_ch.center0_y, in_ch.center1_y);
      s1_dz_r <= abs_diff(in_ch.center0_z, in_ch.center1_z);
      s1_s_r  <= {1'b0, rl_nxt} + {1'b0, rs_nxt};
      s1_t_r  <= rl_nxt - rs_nxt;
      s1_rs_r <= rs_nxt;
    end
  end

  // stage 2: squares
  logic [63:0] s2_dx2_r, s2_dy2_r, s2_dz2_r, s2_s2_r;
  logic [61:0] s2_t2_r;
  logic [31:0] s2_s_r;
  logic [30:0] s2_rs_r;
  logic [63:0] dx2_nxt, dy2_nxt, dz2_nxt, ss_nxt;
  logic [61:0] tt_nxt;

  assign dx2_nxt = s1_dx_r * s1_dx_r;
  assign dy2_nxt = s1_dy_r * s1_dy_r;
  assign dz2_nxt = s1_dz_r * s1_dz_r;
  assign ss_nxt  = s1_s_r * s1_s_r;
  assign tt_nxt  = s1_t_r * s1_t_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dx2_r <= dx2_nxt;
      s2_dy2_r <= dy2_nxt;
      s2_dz2_r <= dz2_nxt;
      s2_s2_r  <= ss_nxt;
      s2_t2_r  <= tt_nxt;
      s2_s_r   <= s1_s_r;
      s2_rs_r  <= s1_rs_r;
    end
  end

  // stage 3: squared distance and exact contact tests
  logic [65:0]       sq_d2_r   [SQN];
  logic [36:0]       sq_rem_r  [SQN];
  logic [34:0]       sq_root_r [SQN+1];
  spo_pkg::sq_side_t sq_side_r [SQN+1];
  logic [65:0]       d2_nxt;
  spo_pkg::sq_side_t sq_side_nxt;

  always_comb begin
    d2_nxt                  = 66'(s2_dx2_r) + 66'(s2_dy2_r) + 66'(s2_dz2_r);
    sq_side_nxt.s           = s2_s_r;
    sq_side_nxt.t2          = s2_t2_r;
    sq_side_nxt.rs          = s2_rs_r;
    sq_side_nxt.touching    = d2_nxt <= 66'(s2_s2_r);
    sq_side_nxt.contained   = d2_nxt <= 66'(s2_t2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_d2_r[0]   <= d2_nxt;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_side_r[0] <= sq_side_nxt;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    logic [69:0] rad;
    logic [36:0] sq_rsh;
    logic [36:0] sq_trial;
    logic        sq_ge;

    assign rad      = {4'b0, sq_d2_r[k]};
    assign sq_rsh   = {sq_rem_r[k][34:0], rad[2*(SQN-1-k)+1 -: 2]};
    assign sq_trial = {sq_root_r[k], 2'b01};
    assign sq_ge    = sq_rsh >= sq_trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sq_root_r[k+1] <= {sq_root_r[k][33:0], sq_ge};
        sq_side_r[k+1] <= sq_side_r[k];
      end
    end

    if (k < SQN - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          sq_d2_r[k+1]  <= sq_d2_r[k];
          sq_rem_r[k+1] <= sq_ge ? sq_rsh - sq_trial : sq_rsh;
        end
      end
    end
  end

  // stage a: depth, lens height, case select
  logic [32:0]       a_d_r;
  logic [31:0]       a_h_r, a_s_r;
  logic [61:0]       a_t2_r;
  logic [30:0]       a_rs_r;
  logic              a_touch_r, a_cont_r, a_sph_r;
  logic signed [31:0] a_pen_r;
  logic signed [35:0] pen_full;
  logic signed [31:0] pen_nxt;
  spo_pkg::sq_side_t sq_last;
  logic [34:0]       d_fin;

  assign sq_last  = sq_side_r[SQN];
  assign d_fin    = sq_root_r[SQN];
  assign pen_full = $signed({1'b0, d_fin}) - $signed({4'b0, sq_last.s});

  always_comb begin
    if (!pen_full[35]) begin
      pen_nxt = '0;
    end else if (pen_full < -36'sd2147483648) begin
      pen_nxt = 32'sh8000_0000;
    end else begin
      pen_nxt = pen_full[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d_r     <= d_fin[32:0];
      a_h_r     <= sq_last.s - d_fin[31:0];
      a_s_r     <= sq_last.s;
      a_t2_r    <= sq_last.t2;
      a_rs_r    <= sq_last.rs;
      a_touch_r <= sq_last.touching;
      a_cont_r  <= sq_last.contained;
      a_sph_r   <= sq_last.contained || (d_fin == '0);
      a_pen_r   <= pen_nxt;
    end
  end

  // stage b: products of distance, radius sum, lens height and smaller radius
  logic [65:0] b_dd_r;
  logic [64:0] b_ds_r;
  logic [63:0] b_hh_r;
  logic [61:0] b_rr_r, b_t2_r;
  logic [30:0] b_rs_r;
  logic [32:0] b_d_r;
  logic        b_touch_r, b_cont_r, b_sph_r;
  logic signed [31:0] b_pen_r;
  logic [65:0] dd_nxt;
  logic [64:0] ds_nxt;
  logic [63:0] hh_nxt;
  logic [61:0] rr_nxt;

  assign dd_nxt = a_d_r * a_d_r;
  assign ds_nxt = a_d_r * a_s_r;
  assign hh_nxt = a_h_r * a_h_r;
  assign rr_nxt = a_rs_r * a_rs_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b_dd_r    <= dd_nxt;
      b_ds_r    <= ds_nxt;
      b_hh_r    <= hh_nxt;
      b_rr_r    <= rr_nxt;
      b_t2_r    <= a_t2_r;
      b_rs_r    <= a_rs_r;
      b_d_r     <= a_d_r;
      b_touch_r <= a_touch_r;
      b_cont_r  <= a_cont_r;
      b_sph_r   <= a_sph_r;
      b_pen_r   <= a_pen_r;
    end
  end

  // stage c: lens polynomial, operand and divisor select
  logic [63:0] c_opa_r;
  logic [68:0] c_opb_r;
  logic [EW-1:0] c_e_r;
  logic        c_touch_r, c_cont_r, c_sph_r;
  logic signed [31:0] c_pen_r;
  logic [67:0] psum, pt3, poly;
  logic [EW-1:0] e_nxt;

  always_comb begin
    psum = 68'(b_dd_r) + {2'b0, b_ds_r, 1'b0};
    pt3  = 68'({b_t2_r, 1'b0}) + 68'(b_t2_r);
    poly = (psum >= pt3) ? psum - pt3 : '0;
    if (b_sph_r) begin
      e_nxt = EW'(3);
    end else begin
      e_nxt = EW'({b_d_r, 3'b0}) + EW'({b_d_r, 2'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_opa_r   <= b_sph_r ? 64'(b_rr_r) : b_hh_r;
      c_opb_r   <= b_sph_r ? 69'(b_rs_r) : 69'(poly);
      c_e_r     <= e_nxt;
      c_touch_r <= b_touch_r;
      c_cont_r  <= b_cont_r;
      c_sph_r   <= b_sph_r;
      c_pen_r   <= b_pen_r;
    end
  end

  // stage d: partial products of the first wide product
  logic [54:0] m_pp_r [6];
  logic [EW-1:0] m_e_r;
  logic        m_touch_r, m_cont_r, m_sph_r;
  logic signed [31:0] m_pen_r;

  for (genvar i = 0; i < 2; i++) begin : g_ppa
    for (genvar j = 0; j < 3; j++) begin : g_ppb
      logic [54:0] pp_nxt;
      assign pp_nxt = c_opa_r[32*i +: 32] * c_opb_r[23*j +: 23];
      always_ff @(posedge clk) begin
        if (en) begin
          m_pp_r[3*i+j] <= pp_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_e_r     <= c_e_r;
      m_touch_r <= c_touch_r;
      m_cont_r  <= c_cont_r;
      m_sph_r   <= c_sph_r;
      m_pen_r   <= c_pen_r;
    end
  end

  // stage e: sum partial products, pick the pi factor
  logic [MW-1:0] p_m1_r;
  logic [35:0]   p_k_r;
  logic [EW-1:0] p_e_r;
  logic          p_touch_r, p_cont_r;
  logic signed [31:0] p_pen_r;
  logic [MW-1:0] m1_nxt;

  always_comb begin
    m1_nxt = '0;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 3; j++) begin
        m1_nxt = m1_nxt + (MW'(m_pp_r[3*i+j]) << (32*i + 23*j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_m1_r    <= m1_nxt;
      p_k_r     <= m_sph_r ? spo_pkg::PI4_Q32 : 36'(spo_pkg::PI_Q32);
      p_e_r     <= m_e_r;
      p_touch_r <= m_touch_r;
      p_cont_r  <= m_cont_r;
      p_pen_r   <= m_pen_r;
    end
  end

  // stage f: partial products with pi
  logic [62:0] f_pp_r [5];
  logic [EW-1:0] f_e_r;
  logic          f_touch_r, f_cont_r;
  logic signed [31:0] f_pen_r;
  logic [134:0]  m1_pad;

  assign m1_pad = 135'(p_m1_r);

  for (genvar i = 0; i < 5; i++) begin : g_ppk
    logic [62:0] ppk_nxt;
    assign ppk_nxt = m1_pad[27*i +: 27] * p_k_r;
    always_ff @(posedge clk) begin
      if (en) begin
        f_pp_r[i] <= ppk_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_e_r     <= p_e_r;
      f_touch_r <= p_touch_r;
      f_cont_r  <= p_cont_r;
      f_pen_r   <= p_pen_r;
    end
  end

  // stage g: full numerator, drop the fixed-point scale
  logic [NW-1:0] g_n_r;
  logic [EW-1:0] g_e_r;
  logic          g_touch_r, g_cont_r;
  logic signed [31:0] g_pen_r;
  logic [XW-1:0] x_nxt;

  always_comb begin
    x_nxt = '0;
    for (int i = 0; i < 5; i++) begin
      x_nxt = x_nxt + (XW'(f_pp_r[i]) << (27*i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_n_r     <= x_nxt[XW-1:SHIFT];
      g_e_r     <= f_e_r;
      g_touch_r <= f_touch_r;
      g_cont_r  <= f_cont_r;
      g_pen_r   <= f_pen_r;
    end
  end

  // stage h: saturation test and divider entry
  logic [EW-1:0]        dv_rem_r  [DVN];
  logic [DVN-1:0]       dv_q_r    [DVN+1];
  spo_pkg::dv_side_t    dv_side_r [DVN+1];
  spo_pkg::dv_side_t    dv_side_nxt;
  logic [HW-1:0]        n_hi;

  assign n_hi = g_n_r[NW-1:DVN];

  always_comb begin
    dv_side_nxt.touching  = g_touch_r;
    dv_side_nxt.contained = g_cont_r;
    dv_side_nxt.pen       = g_pen_r;
    dv_side_nxt.sat       = CMPW'(n_hi) >= CMPW'(g_e_r);
    dv_side_nxt.e         = g_e_r;
    dv_side_nxt.nlow      = g_n_r[DVN-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0]  <= EW'(n_hi);
      dv_q_r[0]    <= '0;
      dv_side_r[0] <= dv_side_nxt;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < DVN; j++) begin : g_div
    logic [EW:0] dv_rsh;
    logic        dv_ge;

    assign dv_rsh = {dv_rem_r[j], dv_side_r[j].nlow[DVN-1-j]};
    assign dv_ge  = dv_rsh >= {1'b0, dv_side_r[j].e};

    always_ff @(posedge clk) begin
      if (en) begin
        dv_q_r[j+1]    <= {dv_q_r[j][DVN-2:0], dv_ge};
        dv_side_r[j+1] <= dv_side_r[j];
      end
    end

    if (j < DVN - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem_r[j+1] <= dv_ge ? EW'(dv_rsh - {1'b0, dv_side_r[j].e}) : EW'(dv_rsh);
        end
      end
    end
  end

  // output register
  spo_pkg::dv_side_t dv_last;
  logic [spo_pkg::VOL_W-1:0] vol_nxt;
  logic o_touch_r, o_cont_r;
  logic signed [31:0] o_pen_r;
  logic [spo_pkg::VOL_W-1:0] o_vol_r;

  assign dv_last = dv_side_r[DVN];

  always_comb begin
    if (!dv_last.touching) begin
      vol_nxt = '0;
    end else if (dv_last.sat) begin
      vol_nxt = spo_pkg::VOL_MAX;
    end else begin
      vol_nxt = dv_q_r[DVN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_touch_r <= dv_last.touching;
      o_cont_r  <= dv_last.contained;
      o_pen_r   <= dv_last.pen;
      o_vol_r   <= vol_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.touching          = o_touch_r;
  assign out_ch.contained         = o_cont_r;
  assign out_ch.penetration_depth = o_pen_r;
  assign out_ch.overlap_volume    = o_vol_r;

endmodule

`default_nettype wire

[hdl/spo_checker.sv]
// ----------------------------------------------------------------------------
// spo_checker
// port-level checks on the result channel of sphere_pair_overlap
// ----------------------------------------------------------------------------
`default_nettype none

module spo_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic                             touching,
  input wire logic                             contained,
  input wire logic signed [spo_pkg::CRD_W-1:0] penetration_depth,
  input wire logic [spo_pkg::VOL_W-1:0]        overlap_volume
);

  // a stalled result beat stays valid and holds its volume and depth
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(overlap_volume)
      && $stable(penetration_depth))
    else $error("result beat changed while stalled");

  a_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && contained |-> touching)
    else $error("contained without touching");

  a_apart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !touching |-> overlap_volume == '0 && penetration_depth == '0)
    else $error("apart spheres with volume or depth");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> penetration_depth[spo_pkg::CRD_W-1] || penetration_depth == '0)
    else $error("positive depth");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sphere_pair_overlap spo_checker u_spo_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .touching          (out_ch.touching),
  .contained         (out_ch.contained),
  .penetration_depth (out_ch.penetration_depth),
  .overlap_volume    (out_ch.overlap_volume)
);

`default_nettype wire
